### sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the current-sense averager.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/dcsma_pkg.sv
// Package of the dual current-sense moving average: widths, register codes,
// divider constants and the divider status type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dcsma_pkg;

    localparam int WIN_LOG2     = 4;
    localparam int WINDOW_DEPTH = 1 << WIN_LOG2;
    localparam int SAMPLE_W     = 12;
    localparam int SUM_W        = SAMPLE_W + WIN_LOG2;

    localparam int STEP_W    = 18;
    localparam int HALF_W    = 23;
    localparam int GAIN_W    = 24;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd2;

    localparam logic [STEP_W-1:0] STEP_RST = 18'd206250;
    localparam logic [HALF_W-1:0] HALF_RST = 23'd1650000;
    localparam logic [GAIN_W-1:0] GAIN_RST = 24'd936229;

    localparam int VOLT_W     = 22;
    localparam int CUR_W      = 31;
    localparam int PWR_W      = 34;
    localparam int VOLT_SHIFT = 8 + WIN_LOG2;
    localparam int CUR_FRAC   = 16;
    localparam int DIFF_W     = HALF_W + 1;

    localparam int MX_W   = 25;
    localparam int MY_W   = 32;
    localparam int PROD_W = MX_W + MY_W;

    // Power is divided by 2000000 (mean) or 1000000 (channel B): a shift by
    // 7 or 6 bits followed by a long division by 15625.
    localparam int          DIV_IN_W   = 46;
    localparam int          QUO_W      = 33;
    localparam int          REM_W      = 14;
    localparam int unsigned DIV_K      = 15625;
    localparam int          MEAN_SHIFT = 7;
    localparam int          PB_SHIFT   = 6;

    localparam int IN_DATA_W  = 2 * SAMPLE_W;
    localparam int OUT_FLD_W  = 2 * VOLT_W + 2 * CUR_W + 2 * PWR_W;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_FLD_W;

    typedef struct packed {
        logic             busy;
        logic [QUO_W-1:0] quo;
    } t_div_stat;

endpackage

`default_nettype wire

### sv/dual_current_sense_moving_average.sv
// Channel   Direction  Handshake                     Payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready   sample pair
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready   voltages, currents, powers
// cfg       in         i_cfg_valid/o_cfg_ready           register index and data
//
// A word that yields no result goes through ST_READ back to idle; one that yields a
// result goes on through ST_MV, ST_MI, ST_SI, ST_MP, ST_DS, ST_DV and the three-digit
// division by 15625 in ST_DW to ST_OUT. One word is processed at a time.
// Synchronous active-low reset; the sample rings read as zero until written.
// A stalled output holds its result while the next word is accepted.
// Depends on dcsma_pkg, dcsma_ram, dcsma_div and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dual_current_sense_moving_average import dcsma_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // sample_a [11:0], sample_b [23:12]
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // voltage_a_uv [21:0], current_a_ua [52:22], voltage_b_uv [74:53],
    // current_b_ua [105:75], power_mean_uw [139:106], power_b_uw [173:140]
    output logic      [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_data
);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_READ = 10'b0000000010,
        ST_MV   = 10'b0000000100,
        ST_MI   = 10'b0000001000,
        ST_SI   = 10'b0000010000,
        ST_MP   = 10'b0000100000,
        ST_DS   = 10'b0001000000,
        ST_DV   = 10'b0010000000,
        ST_DW   = 10'b0100000000,
        ST_OUT  = 10'b1000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [STEP_W-1:0]   r_cfg_step;
    logic [HALF_W-1:0]   r_cfg_half;
    logic [GAIN_W-1:0]   r_cfg_gain;
    logic [WIN_LOG2-1:0] r_slot;
    logic [WIN_LOG2-1:0] slot_nx;
    logic                r_wrap;
    logic                r_full;
    logic [SUM_W-1:0]    r_sum_a;
    logic [SUM_W-1:0]    r_sum_b;
    logic [SAMPLE_W-1:0] r_smp_a;
    logic [SAMPLE_W-1:0] r_smp_b;
    logic [SAMPLE_W-1:0] old_a;
    logic [SAMPLE_W-1:0] old_b;
    logic [IN_DATA_W-1:0] ram_rdata;

    logic signed [MX_W-1:0]   mx_a;
    logic signed [MX_W-1:0]   mx_b;
    logic signed [MY_W-1:0]   my_a;
    logic signed [MY_W-1:0]   my_b;
    logic signed [PROD_W-1:0] mul_a;
    logic signed [PROD_W-1:0] mul_b;
    logic signed [PROD_W-1:0] r_prod_a;
    logic signed [PROD_W-1:0] r_prod_b;
    logic signed [PROD_W-1:0] r_psum;
    logic signed [PROD_W-1:0] mag_mean;
    logic signed [PROD_W-1:0] mag_b;

    logic [VOLT_W-1:0]        va_a;
    logic [VOLT_W-1:0]        va_b;
    logic signed [DIFF_W-1:0] diff_a;
    logic signed [DIFF_W-1:0] diff_b;
    logic [VOLT_W-1:0]        r_va_a;
    logic [VOLT_W-1:0]        r_va_b;
    logic signed [CUR_W-1:0]  r_ia_a;
    logic signed [CUR_W-1:0]  r_ia_b;
    logic                     r_neg_mean;
    logic                     r_neg_b;
    logic [PWR_W-1:0]         pwr_mean;
    logic [PWR_W-1:0]         pwr_b;

    logic                  in_acc;
    logic                  out_free;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    t_div_stat             div_mean;
    t_div_stat             div_b;

    function automatic logic signed [CUR_W-1:0] sat_cur(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        logic signed [PROD_W-1:0] q;
        logic [PROD_W-CUR_W:0]    top;
        t   = p + (p[PROD_W-1] ? PROD_W'((1 << CUR_FRAC) - 1) : PROD_W'(0));
        q   = t >>> CUR_FRAC;
        top = q[PROD_W-1:CUR_W-1];
        if ((&top) || !(|top)) begin
            sat_cur = q[CUR_W-1:0];
        end else if (q[PROD_W-1]) begin
            sat_cur = {1'b1, {(CUR_W - 1){1'b0}}};
        end else begin
            sat_cur = {1'b0, {(CUR_W - 1){1'b1}}};
        end
    endfunction

    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    dcsma_ram #(
        .WIDTH (IN_DATA_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_READ),
        .i_waddr (r_slot),
        .i_wdata ({r_smp_b, r_smp_a}),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    assign slot_nx = r_slot + WIN_LOG2'(1);
    assign old_a   = r_wrap ? ram_rdata[SAMPLE_W-1:0] : '0;
    assign old_b   = r_wrap ? ram_rdata[IN_DATA_W-1:SAMPLE_W] : '0;

    assign va_a   = r_prod_a[VOLT_SHIFT +: VOLT_W];
    assign va_b   = r_prod_b[VOLT_SHIFT +: VOLT_W];
    assign diff_a = $signed({1'b0, r_cfg_half}) - $signed(DIFF_W'(va_a));
    assign diff_b = $signed({1'b0, r_cfg_half}) - $signed(DIFF_W'(va_b));

    always_comb begin
        if (r_state == ST_MV) begin
            mx_a = MX_W'(r_sum_a);
            mx_b = MX_W'(r_sum_b);
            my_a = MY_W'(r_cfg_step);
            my_b = MY_W'(r_cfg_step);
        end else if (r_state == ST_MI) begin
            mx_a = {{(MX_W - DIFF_W){diff_a[DIFF_W-1]}}, diff_a};
            mx_b = {{(MX_W - DIFF_W){diff_b[DIFF_W-1]}}, diff_b};
            my_a = MY_W'(r_cfg_gain);
            my_b = MY_W'(r_cfg_gain);
        end else begin
            mx_a = MX_W'(r_va_a);
            mx_b = MX_W'(r_va_b);
            my_a = {{(MY_W - CUR_W){r_ia_a[CUR_W-1]}}, r_ia_a};
            my_b = {{(MY_W - CUR_W){r_ia_b[CUR_W-1]}}, r_ia_b};
        end
    end

    assign mul_a = mx_a * my_a;
    assign mul_b = mx_b * my_b;

    assign mag_mean = r_psum[PROD_W-1] ? -r_psum : r_psum;
    assign mag_b    = r_prod_b[PROD_W-1] ? -r_prod_b : r_prod_b;

    dcsma_div u_div_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_DV),
        .i_mag   (mag_mean[MEAN_SHIFT +: DIV_IN_W]),
        .o_stat  (div_mean)
    );

    dcsma_div u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_DV),
        .i_mag   (mag_b[PB_SHIFT +: DIV_IN_W]),
        .o_stat  (div_b)
    );

    assign pwr_mean = r_neg_mean ? -PWR_W'(div_mean.quo) : PWR_W'(div_mean.quo);
    assign pwr_b    = r_neg_b ? -PWR_W'(div_b.quo) : PWR_W'(div_b.quo);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = r_full ? ST_MV : ST_IDLE;
            ST_MV:   n_state = ST_MI;
            ST_MI:   n_state = ST_SI;
            ST_SI:   n_state = ST_MP;
            ST_MP:   n_state = ST_DS;
            ST_DS:   n_state = ST_DV;
            ST_DV:   n_state = ST_DW;
            ST_DW: begin
                if (!div_mean.busy) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg_step  <= STEP_RST;
            r_cfg_half  <= HALF_RST;
            r_cfg_gain  <= GAIN_RST;
            r_slot      <= '0;
            r_wrap      <= 1'b0;
            r_full      <= 1'b0;
            r_sum_a     <= '0;
            r_sum_b     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_STEP: r_cfg_step <= i_cfg_data[STEP_W-1:0];
                    CFG_HALF: r_cfg_half <= i_cfg_data[HALF_W-1:0];
                    CFG_GAIN: r_cfg_gain <= i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == ST_READ) begin
                r_sum_a <= r_sum_a - SUM_W'(old_a) + SUM_W'(r_smp_a);
                r_sum_b <= r_sum_b - SUM_W'(old_b) + SUM_W'(r_smp_b);
                r_slot  <= slot_nx;
                if (slot_nx == '0) begin
                    r_wrap <= 1'b1;
                end
                if (!r_full && slot_nx == '1) begin
                    r_full <= 1'b1;
                end
            end
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_m_axis_tvalid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_smp_a <= i_s_axis_tdata[SAMPLE_W-1:0];
            r_smp_b <= i_s_axis_tdata[IN_DATA_W-1:SAMPLE_W];
        end
        if (r_state == ST_MV || r_state == ST_MI || r_state == ST_MP) begin
            r_prod_a <= mul_a;
            r_prod_b <= mul_b;
        end
        if (r_state == ST_MI) begin
            r_va_a <= va_a;
            r_va_b <= va_b;
        end
        if (r_state == ST_SI) begin
            r_ia_a <= sat_cur(r_prod_a);
            r_ia_b <= sat_cur(r_prod_b);
        end
        if (r_state == ST_DS) begin
            r_psum <= r_prod_a + r_prod_b;
        end
        if (r_state == ST_DV) begin
            r_neg_mean <= r_psum[PROD_W-1];
            r_neg_b    <= r_prod_b[PROD_W-1];
        end
        if (r_state == ST_OUT && out_free) begin
            r_out_data <= {{OUT_PAD_W{1'b0}}, pwr_b, pwr_mean,
                           r_ia_b, r_va_b, r_ia_a, r_va_a};
        end
    end

    `ASSERT_IMPL(a_out_needs_full, i_clk, i_rst_n, r_state == ST_OUT, r_full)
    `ASSERT_IMPL(a_div_lockstep, i_clk, i_rst_n, 1'b1, div_mean.busy == div_b.busy)
    `ASSERT_IMPL(a_div_idle_at_start, i_clk, i_rst_n, r_state == ST_DV, !div_mean.busy)
    `ASSERT_NEXT(a_accept_reads, i_clk, i_rst_n, in_acc, r_state == ST_READ)

endmodule

`default_nettype wire

### sv/dcsma_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dcsma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### sv/dcsma_div.sv
// Divider of a magnitude by the constant 15625, sixteen quotient bits at a time.
// Each digit takes a reciprocal multiply, then a remainder update.
// Depends on dcsma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dcsma_div import dcsma_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [DIV_IN_W-1:0] i_mag,
    output t_div_stat                o_stat
);

    localparam int                DIG_W  = 16;
    localparam int                DIGITS = 3;
    localparam int                SRC_W  = DIGITS * DIG_W;
    localparam int                PART_W = REM_W + DIG_W;
    localparam int                RCP_W  = 31;
    localparam int                EST_W  = PART_W + RCP_W;
    localparam int                RCP_SH = PART_W + REM_W;
    localparam int                CNT_W  = 2;
    localparam logic [RCP_W-1:0]  RECIP  = 31'd1125899907;
    localparam logic [REM_W-1:0]  K_DIV  = REM_W'(DIV_K);

    logic              r_busy;
    logic              r_phase;
    logic [CNT_W-1:0]  r_cnt;
    logic [REM_W-1:0]  r_rem;
    logic [SRC_W-1:0]  r_src;
    logic [QUO_W-1:0]  r_quo;
    logic [PART_W-1:0] r_part;
    logic [DIG_W-1:0]  r_dig;
    logic [PART_W-1:0] part;
    logic [EST_W-1:0]  est;
    logic [PART_W-1:0] back;
    logic [PART_W-1:0] left;

    // The reciprocal is exact for every partial dividend below 2^30.
    assign part = {r_rem, r_src[SRC_W-1 -: DIG_W]};
    assign est  = {{RCP_W{1'b0}}, part} * {{PART_W{1'b0}}, RECIP};
    assign back = {{REM_W{1'b0}}, r_dig} * {{DIG_W{1'b0}}, K_DIV};
    assign left = r_part - back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_cnt   <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_phase <= 1'b0;
            r_cnt   <= CNT_W'(DIGITS);
        end else if (r_busy) begin
            r_phase <= !r_phase;
            if (r_phase) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_src <= SRC_W'(i_mag);
            r_quo <= '0;
        end else if (r_busy) begin
            if (!r_phase) begin
                r_part <= part;
                r_dig  <= est[RCP_SH +: DIG_W];
            end else begin
                r_rem <= left[REM_W-1:0];
                r_src <= {r_src[SRC_W-DIG_W-1:0], {DIG_W{1'b0}}};
                r_quo <= {r_quo[QUO_W-DIG_W-1:0], r_dig};
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.quo  = r_quo;

endmodule

`default_nettype wire

### tb/tb_dual_current_sense_moving_average.sv
// Self-checking testbench for dual_current_sense_moving_average: drives sample pairs with random gaps
// and register writes, and compares each output word with a local predictor.
// Depends on dcsma_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_dual_current_sense_moving_average;
    import dcsma_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 60;
    localparam int STALL_LIMIT   = 5000;
    localparam int SEGMENTS      = 10;
    localparam int SEG_ITEMS     = 150;
    localparam longint CUR_HI = 64'sd1073741823;
    localparam longint CUR_LO = -64'sd1073741824;
    localparam longint PWR_HI = 64'sd8589934591;
    localparam longint PWR_LO = -64'sd8589934592;

    typedef struct packed {
        logic [PWR_W-1:0]  pwr_b;
        logic [PWR_W-1:0]  pwr_mean;
        logic [CUR_W-1:0]  cur_b;
        logic [VOLT_W-1:0] volt_b;
        logic [CUR_W-1:0]  cur_a;
        logic [VOLT_W-1:0] volt_a;
    } t_reading;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_STEP;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    logic [STEP_W-1:0]   step_q8 = STEP_RST;
    logic [HALF_W-1:0]   half_ref_uv = HALF_RST;
    logic [GAIN_W-1:0]   inv_gain_q16 = GAIN_RST;
    logic [SAMPLE_W-1:0] ring_a [WINDOW_DEPTH] = '{default: '0};
    logic [SAMPLE_W-1:0] ring_b [WINDOW_DEPTH] = '{default: '0};
    int                  sum_a = 0;
    int                  sum_b = 0;
    int                  wr_slot = 0;
    bit                  win_full = 1'b0;
    t_reading            pending_readings [$];

    int mismatches = 0;
    int idle_cycles = 0;
    int rx_stall_left = 0;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;

    dual_current_sense_moving_average u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint mean_uv(input int sum);
        return (longint'(sum) * longint'(step_q8)) / (WINDOW_DEPTH * 256);
    endfunction

    function automatic longint current_ua(input longint v_uv);
        return clamp(((longint'(half_ref_uv) - v_uv) * longint'(inv_gain_q16)) / 65536,
                     CUR_LO, CUR_HI);
    endfunction

    task automatic advance_windows(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b);
        t_reading r;
        longint   va, vb, ia, ib, pa, pb, pm, pbu;
        bit       emit;
        emit = win_full;
        sum_a = sum_a - int'(ring_a[wr_slot]) + int'(a);
        sum_b = sum_b - int'(ring_b[wr_slot]) + int'(b);
        ring_a[wr_slot] = a;
        ring_b[wr_slot] = b;
        wr_slot = (wr_slot + 1) % WINDOW_DEPTH;
        if (!win_full && wr_slot == WINDOW_DEPTH - 1) win_full = 1'b1;
        if (emit) begin
            va = mean_uv(sum_a);
            vb = mean_uv(sum_b);
            ia = current_ua(va);
            ib = current_ua(vb);
            pa = va * ia;
            pb = vb * ib;
            pm  = clamp((pa + pb) / 2000000, PWR_LO, PWR_HI);
            pbu = clamp(pb / 1000000, PWR_LO, PWR_HI);
            r.volt_a   = va[VOLT_W-1:0];
            r.cur_a    = ia[CUR_W-1:0];
            r.volt_b   = vb[VOLT_W-1:0];
            r.cur_b    = ib[CUR_W-1:0];
            r.pwr_mean = pm[PWR_W-1:0];
            r.pwr_b    = pbu[PWR_W-1:0];
            pending_readings.push_back(r);
        end
    endtask

    // The valid stays high after acceptance so that back-to-back words need no toggle.
    task automatic send_pair(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {b, a};
        do @(posedge i_clk); while (!o_s_axis_tready);
        advance_windows(a, b);
    endtask

    task automatic quiesce();
        i_s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_STEP: step_q8      = data[STEP_W-1:0];
            CFG_HALF: half_ref_uv  = data[HALF_W-1:0];
            CFG_GAIN: inv_gain_q16 = data[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [CFG_W-1:0] step, input logic [CFG_W-1:0] half,
                                input logic [CFG_W-1:0] gain);
        write_reg(CFG_STEP, step);
        write_reg(CFG_HALF, half);
        write_reg(CFG_GAIN, gain);
        write_reg(CFG_SPARE, CFG_W'($urandom()));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_reg_value(input logic [CFG_W-1:0] rst_val);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return rst_val;
            default: return CFG_W'($urandom());
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] next_sample(input logic [SAMPLE_W-1:0] prev);
        int r, v;
        r = $urandom_range(0, 9);
        if (r < 6) return SAMPLE_W'($urandom());
        if (r < 8) return $urandom_range(0, 1) ? '1 : '0;
        v = int'(prev) + $urandom_range(0, 64) - 32;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v[SAMPLE_W-1:0];
    endfunction

    // No output is allowed until the window holds a full set of samples.
    task automatic test_window_fill();
        for (int n = 0; n < 20; n++) begin
            case (n % 4)
                0: send_pair(12'h000, 12'hFFF);
                1: send_pair(12'hFFF, 12'h000);
                2: send_pair(12'hAAA, 12'h555);
                default: send_pair(12'h555, 12'hAAA);
            endcase
            if (n == WINDOW_DEPTH - 2) quiesce();
        end
        quiesce();
    endtask

    task automatic run_corner(input logic [CFG_W-1:0] step, input logic [CFG_W-1:0] half,
                              input logic [CFG_W-1:0] gain);
        quiesce();
        program_regs(step, half, gain);
        repeat (WINDOW_DEPTH) send_pair(12'hFFF, 12'hFFF);
        send_pair(12'h000, 12'hFFF);
        send_pair(12'hFFF, 12'h000);
        send_pair(12'h000, 12'h000);
    endtask

    task automatic test_register_extremes();
        tx_idle_on = 1'b0;
        run_corner(24'd262143, 24'd0, 24'hFFFFFF);
        run_corner(24'd0, 24'hFFFFFF, 24'hFFFFFF);
        run_corner(24'd0, 24'd0, 24'd0);
        run_corner(24'hFFFFFF, 24'd5000000, 24'd1);
        run_corner(CFG_W'(STEP_RST), CFG_W'(HALF_RST), CFG_W'(GAIN_RST));
        tx_idle_on = 1'b1;
        quiesce();
    endtask

    task automatic test_random_traffic();
        logic [SAMPLE_W-1:0] a, b;
        a = 12'd2048;
        b = 12'd2048;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            quiesce();
            program_regs(pick_reg_value(CFG_W'(STEP_RST)), pick_reg_value(CFG_W'(HALF_RST)),
                         pick_reg_value(CFG_W'(GAIN_RST)));
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < SEG_ITEMS; n++) begin
                a = next_sample(a);
                b = next_sample(b);
                send_pair(a, b);
            end
        end
        quiesce();
    endtask

    task automatic check_field(input string fname, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (rx_stall_left > 0) begin
            i_m_axis_tready <= 1'b0;
            rx_stall_left   <= rx_stall_left - 1;
        end else if (rx_idle_on && $urandom_range(0, 99) < 20) begin
            i_m_axis_tready <= 1'b0;
            rx_stall_left   <= pick_gap();
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_readings
        t_reading got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[OUT_FLD_W-1:0];
            if (pending_readings.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected output word, expected none, actual %h",
                         $time, o_m_axis_tdata);
            end else begin
                want = pending_readings.pop_front();
                check_field("voltage_a_uv", want.volt_a, got.volt_a);
                check_field("current_a_ua", $signed(want.cur_a), $signed(got.cur_a));
                check_field("voltage_b_uv", want.volt_b, got.volt_b);
                check_field("current_b_ua", $signed(want.cur_b), $signed(got.cur_b));
                check_field("power_mean_uw", $signed(want.pwr_mean), $signed(got.pwr_mean));
                check_field("power_b_uw", $signed(want.pwr_b), $signed(got.pwr_b));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_window_fill();
        test_register_extremes();
        test_random_traffic();
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
